[rtl/core/crb_pkg.sv]
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types and constants of the chunk ring buffer.
// ----------------------------------------------------------------------------
package crb_pkg;

   localparam logic [2:0] CMD_WRITE_BEGIN = 3'd0;
   localparam logic [2:0] CMD_WRITE_WORD  = 3'd1;
   localparam logic [2:0] CMD_COMMIT      = 3'd2;
   localparam logic [2:0] CMD_PEEK        = 3'd3;
   localparam logic [2:0] CMD_READ_WORD   = 3'd4;
   localparam logic [2:0] CMD_RECLAIM     = 3'd5;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SPACE = 2'd1;
   localparam logic [1:0] STAT_NO_CHUNK = 2'd2;

   localparam logic [1:0] CSR_OVERWRITE  = 2'd0;
   localparam logic [1:0] CSR_RING_WORDS = 2'd1;

   localparam logic [31:0] MAGIC_VALID = 32'hA1A1A1A1;
   localparam logic [31:0] MAGIC_DEAD  = 32'hD0D0D0D0;
   localparam logic [31:0] MAGIC_ALLOC = 32'hA110CED0;

   localparam logic [12:0] MARGIN_BYTES = 13'd12;
   localparam int          OFF_W        = 10;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HV_WAIT,
      ST_PEEK_WAIT,
      ST_RDW_WAIT,
      ST_DROP_SZ,
      ST_NEXT,
      ST_MOD_ITER,
      ST_DROP_W1,
      ST_DROP_W2,
      ST_OW_CHECK,
      ST_BEGIN_W1,
      ST_BEGIN_W2,
      ST_COMMIT_W2,
      ST_FIN
   } crb_state_type;

endpackage

[rtl/core/chunk_ring_buffer.sv]
// ----------------------------------------------------------------------------
// chunk_ring_buffer
// Ring of 32-bit words holding variable-length chunks with size/magic headers.
// ----------------------------------------------------------------------------
// Command flow: write_word and unused commands respond directly; peek,
//   read_word and reclaim first check the header magic for a valid chunk.
// write_begin in overwrite mode first drops the oldest chunks until it fits.
// One item at a time; the word memory (one read, one write port) sets it.
// Reset: synchronous; a clearing pass zeroes all RING_WORDS_MAX memory words
//   while busy is high. Results are strobed and cannot be stalled.
module chunk_ring_buffer #(
   parameter int RING_WORDS_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [11:0] req_byte_length,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_chunk_bytes,
   output logic [31:0] rsp_payload_word,
   output logic [12:0] rsp_free_bytes,
   output logic [12:0] rsp_used_bytes,
   output logic [10:0] rsp_dropped_chunks,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import crb_pkg::*;

   localparam int AW = $clog2(RING_WORDS_MAX);
   localparam int SW = $clog2(RING_WORDS_MAX + 1);
   localparam int CW = (SW > 11) ? SW : 11;
   localparam int BW = (SW + 2 > 13) ? SW + 2 : 13;
   localparam int RESET_SIZE = (RING_WORDS_MAX < 1024) ? RING_WORDS_MAX : 1024;

   logic [31:0] mem [RING_WORDS_MAX];
   logic [31:0] rd_data_ff;
   logic        mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [31:0] mem_wd;

   crb_state_type state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [11:0] len_ff, len_in;
   logic [1:0]  status_ff, status_in;
   logic [11:0] chunk_ff, chunk_in;
   logic [31:0] payload_ff, payload_in;
   logic [SW-1:0] dropped_ff, dropped_in;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in, waddr_ff, waddr_in, raddr_ff, raddr_in;
   logic [OFF_W-1:0] woff_ff, woff_in, roff_ff, roff_in;
   logic [AW-1:0] nxt_ff, nxt_in, clr_ff, clr_in;
   logic [31:0] n_ff, n_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        ovw_ff, ovw_in;
   logic [SW-1:0] size_ff, size_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [11:0] rsp_chunk_ff;
   logic [31:0] rsp_payload_ff;
   logic [12:0] rsp_free_ff, rsp_used_ff;
   logic [10:0] rsp_dropped_ff;

   logic [SW-1:0] free_w, used_w;
   logic [BW-1:0] free_b, need_b, need_in_b;
   logic [SW:0]   mod_t;
   logic [SW:0]   mod_r;
   logic [CW-1:0] csr_ext;

   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                              input logic [1:0] k,
                                              input logic [SW-1:0] s);
      logic [SW:0] sum;
      sum = (SW+1)'(p) + (SW+1)'(k);
      if (sum >= (SW+1)'(s)) sum = sum - (SW+1)'(s);
      return sum[AW-1:0];
   endfunction

   always_comb begin
      if (wp_ff > rp_ff) free_w = SW'(rp_ff) + size_ff - SW'(wp_ff) - SW'(1);
      else if (wp_ff < rp_ff) free_w = SW'(rp_ff) - SW'(wp_ff) - SW'(1);
      else free_w = size_ff;
      if (wp_ff >= rp_ff) used_w = SW'(wp_ff) - SW'(rp_ff);
      else used_w = SW'(wp_ff) + size_ff - SW'(rp_ff);
      free_b    = BW'({free_w, 2'b00});
      need_b    = BW'(13'(len_ff) + MARGIN_BYTES);
      need_in_b = BW'(13'(req_byte_length) + MARGIN_BYTES);
      mod_t     = {rem_ff, n_ff[31]};
      mod_r     = (mod_t >= (SW+1)'(size_ff)) ? mod_t - (SW+1)'(size_ff) : mod_t;
      csr_ext   = CW'(csr_data);
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      chunk_in   = chunk_ff;
      payload_in = payload_ff;
      dropped_in = dropped_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      waddr_in   = waddr_ff;
      raddr_in   = raddr_ff;
      woff_in    = woff_ff;
      roff_in    = roff_ff;
      nxt_in     = nxt_ff;
      clr_in     = clr_ff;
      n_in       = n_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      ovw_in     = ovw_ff;
      size_in    = size_ff;
      rsp_valid_in = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = wp_ff;
      mem_wd     = 32'd0;
      mem_ra     = ring_add(rp_ff, 2'd1, size_ff);

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(RING_WORDS_MAX - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in     = req_command;
               len_in     = req_byte_length;
               status_in  = STAT_OK;
               chunk_in   = 12'd0;
               payload_in = 32'd0;
               dropped_in = '0;
               state_in   = ST_FIN;
               case (req_command)
                  CMD_WRITE_BEGIN: begin
                     if (ovw_ff) begin
                        if (need_in_b > BW'({size_ff, 2'b00})) status_in = STAT_NO_SPACE;
                        else state_in = ST_OW_CHECK;
                     end else if (free_b < need_in_b) begin
                        status_in = STAT_NO_SPACE;
                     end else begin
                        state_in = ST_BEGIN_W1;
                     end
                  end
                  CMD_WRITE_WORD: begin
                     mem_we  = 1'b1;
                     mem_wa  = waddr_ff;
                     mem_wd  = req_data_word;
                     woff_in = woff_ff + OFF_W'(1);
                     if (woff_ff == '1) waddr_in = ring_add(wp_ff, 2'd2, size_ff);
                     else waddr_in = ring_add(waddr_ff, 2'd1, size_ff);
                  end
                  CMD_COMMIT: begin
                     mem_we   = 1'b1;
                     mem_wa   = wp_ff;
                     mem_wd   = 32'(req_byte_length);
                     n_in     = 32'(wp_ff) + 32'd2 + 32'(req_byte_length[11:2])
                                + 32'(req_byte_length[1:0] != 2'd0);
                     state_in = ST_NEXT;
                  end
                  CMD_PEEK, CMD_READ_WORD, CMD_RECLAIM: begin
                     state_in = ST_HV_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_HV_WAIT: begin
            if (rd_data_ff != MAGIC_VALID) begin
               status_in = STAT_NO_CHUNK;
               state_in  = ST_FIN;
            end else if (cmd_ff == CMD_PEEK) begin
               mem_ra   = rp_ff;
               state_in = ST_PEEK_WAIT;
            end else if (cmd_ff == CMD_READ_WORD) begin
               mem_ra   = raddr_ff;
               state_in = ST_RDW_WAIT;
            end else begin
               mem_ra   = rp_ff;
               state_in = ST_DROP_SZ;
            end
         end
         ST_PEEK_WAIT: begin
            chunk_in = rd_data_ff[11:0];
            roff_in  = '0;
            raddr_in = ring_add(rp_ff, 2'd2, size_ff);
            state_in = ST_FIN;
         end
         ST_RDW_WAIT: begin
            payload_in = rd_data_ff;
            roff_in    = roff_ff + OFF_W'(1);
            if (roff_ff == '1) raddr_in = ring_add(rp_ff, 2'd2, size_ff);
            else raddr_in = ring_add(raddr_ff, 2'd1, size_ff);
            state_in   = ST_FIN;
         end
         ST_DROP_SZ: begin
            n_in     = 32'(rp_ff) + 32'd2 + {2'b00, rd_data_ff[31:2]}
                       + 32'(rd_data_ff[1:0] != 2'd0);
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (n_ff < 32'({size_ff, 1'b0})) begin
               if (n_ff >= 32'(size_ff)) nxt_in = AW'(n_ff - 32'(size_ff));
               else nxt_in = AW'(n_ff);
               state_in = (cmd_ff == CMD_COMMIT) ? ST_COMMIT_W2 : ST_DROP_W1;
            end else begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_MOD_ITER;
            end
         end
         ST_MOD_ITER: begin
            rem_in = mod_r[SW-1:0];
            n_in   = {n_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               nxt_in   = mod_r[AW-1:0];
               state_in = (cmd_ff == CMD_COMMIT) ? ST_COMMIT_W2 : ST_DROP_W1;
            end
         end
         ST_DROP_W1: begin
            mem_we   = 1'b1;
            mem_wa   = rp_ff;
            mem_wd   = 32'd0;
            state_in = ST_DROP_W2;
         end
         ST_DROP_W2: begin
            mem_we   = 1'b1;
            mem_wa   = ring_add(rp_ff, 2'd1, size_ff);
            mem_wd   = MAGIC_DEAD;
            rp_in    = nxt_ff;
            roff_in  = '0;
            raddr_in = ring_add(nxt_ff, 2'd2, size_ff);
            if (cmd_ff == CMD_RECLAIM) begin
               state_in = ST_FIN;
            end else begin
               dropped_in = dropped_ff + SW'(1);
               state_in   = ST_OW_CHECK;
            end
         end
         ST_OW_CHECK: begin
            if (free_b >= need_b) begin
               state_in = ST_BEGIN_W1;
            end else if (dropped_ff >= size_ff) begin
               status_in = STAT_NO_SPACE;
               state_in  = ST_FIN;
            end else begin
               state_in = ST_HV_WAIT;
            end
         end
         ST_BEGIN_W1: begin
            mem_we   = 1'b1;
            mem_wa   = wp_ff;
            mem_wd   = 32'd0;
            state_in = ST_BEGIN_W2;
         end
         ST_BEGIN_W2: begin
            mem_we   = 1'b1;
            mem_wa   = ring_add(wp_ff, 2'd1, size_ff);
            mem_wd   = MAGIC_ALLOC;
            woff_in  = '0;
            waddr_in = ring_add(wp_ff, 2'd2, size_ff);
            state_in = ST_FIN;
         end
         ST_COMMIT_W2: begin
            mem_we   = 1'b1;
            mem_wa   = ring_add(wp_ff, 2'd1, size_ff);
            mem_wd   = MAGIC_VALID;
            wp_in    = nxt_ff;
            woff_in  = '0;
            waddr_in = ring_add(nxt_ff, 2'd2, size_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         if (csr_index == CSR_OVERWRITE) begin
            ovw_in = csr_data[0];
         end else if (csr_index == CSR_RING_WORDS) begin
            if (csr_ext < CW'(8)) size_in = SW'(8);
            else if (csr_ext > CW'(RING_WORDS_MAX)) size_in = SW'(RING_WORDS_MAX);
            else size_in = SW'(csr_ext);
            wp_in    = '0;
            rp_in    = '0;
            woff_in  = '0;
            roff_in  = '0;
            waddr_in = AW'(2);
            raddr_in = AW'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         waddr_ff     <= AW'(2);
         raddr_ff     <= AW'(2);
         woff_ff      <= '0;
         roff_ff      <= '0;
         ovw_ff       <= 1'b0;
         size_ff      <= SW'(RESET_SIZE);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         waddr_ff     <= waddr_in;
         raddr_ff     <= raddr_in;
         woff_ff      <= woff_in;
         roff_ff      <= roff_in;
         ovw_ff       <= ovw_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      len_ff     <= len_in;
      status_ff  <= status_in;
      chunk_ff   <= chunk_in;
      payload_ff <= payload_in;
      dropped_ff <= dropped_in;
      nxt_ff     <= nxt_in;
      n_ff       <= n_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      if (rsp_valid_in) begin
         rsp_status_ff  <= status_ff;
         rsp_chunk_ff   <= chunk_ff;
         rsp_payload_ff <= payload_ff;
         rsp_free_ff    <= free_b[12:0];
         rsp_used_ff    <= 13'({used_w, 2'b00});
         rsp_dropped_ff <= 11'(dropped_ff);
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_chunk_bytes    = rsp_chunk_ff;
   assign rsp_payload_word   = rsp_payload_ff;
   assign rsp_free_bytes     = rsp_free_ff;
   assign rsp_used_bytes     = rsp_used_ff;
   assign rsp_dropped_chunks = rsp_dropped_ff;

endmodule

[rtl/core/crb_checker.sv]
// ----------------------------------------------------------------------------
// crb_checker
// Port-level checks of the chunk ring buffer.
// ----------------------------------------------------------------------------
module crb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_chunk_bytes,
   input logic [31:0] rsp_payload_word
);
   import crb_pkg::*;

   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_NO_SPACE ||
                     rsp_status == STAT_NO_CHUNK))
      else $error("bad status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
         (rsp_chunk_bytes == 12'd0 && rsp_payload_word == 32'd0))
      else $error("failed item returned data");

endmodule

bind chunk_ring_buffer crb_checker u_crb_checker (.*);
